>>> design/wdm_pkg.sv
// ----------------------------------------------------------------------------
// wdm_pkg: shared definitions for the weighted density matrix unit
// Sizes, codes and the control word that the sequencer hands to the
// multiply-accumulate datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wdm_pkg;

    // storage sizing
    localparam int MAX_BASIS    = 64;
    localparam int MAX_ORBITALS = 64;
    localparam int DEPTH        = MAX_BASIS * MAX_ORBITALS;
    localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // orbital counter holds the end value itself, the index part does not
    localparam int K_W          = $clog2(MAX_ORBITALS + 1);
    localparam int K_IDX_W      = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;

    // fixed field widths
    localparam int COEF_W    = 32;
    localparam int DENS_W    = 64;
    localparam int IDX_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int WEIGHT_W  = 17;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int FRAC_BITS = 29;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 17'h1FFFF;

    // weight divider: dividend is (num << 16) + den/2
    localparam int DIV_W     = 23;
    localparam int DIV_CNT_W = 5;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASIS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELL_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELL_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELECTRONS = 3'd3;

    // multiplier operations
    localparam logic [1:0] MAC_NOP  = 2'd0;
    localparam logic [1:0] MAC_PROD = 2'd1;
    localparam logic [1:0] MAC_WLO  = 2'd2;
    localparam logic [1:0] MAC_WHI  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       acc_clr;
        logic       acc_add;
        logic       full;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> design/wdm_coef_ram.sv
// ----------------------------------------------------------------------------
// wdm_coef_ram: coefficient store
// One write port and two registered read ports over the coefficient matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module wdm_coef_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [wdm_pkg::ADDR_W-1:0]   i_waddr,
    input  wire logic [wdm_pkg::COEF_W-1:0]   i_wdata,
    input  wire logic                         i_re,
    input  wire logic [wdm_pkg::ADDR_W-1:0]   i_raddr_a,
    input  wire logic [wdm_pkg::ADDR_W-1:0]   i_raddr_b,
    output logic      [wdm_pkg::COEF_W-1:0]   o_rdata_a,
    output logic      [wdm_pkg::COEF_W-1:0]   o_rdata_b
);

    logic [wdm_pkg::COEF_W-1:0] mem [wdm_pkg::DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> design/wdm_div.sv
// ----------------------------------------------------------------------------
// wdm_div: partial shell weight divider
// Restoring divider, one quotient bit per cycle, rounds to nearest and
// saturates the quotient to the Q1.16 weight range.
// ----------------------------------------------------------------------------
`default_nettype none

module wdm_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [wdm_pkg::CFG_W-1:0]     i_num,
    input  wire logic [wdm_pkg::CFG_W-1:0]     i_den,
    output logic                               o_done,
    output logic      [wdm_pkg::WEIGHT_W-1:0]  o_weight
);

    logic                            r_busy;
    logic [wdm_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [wdm_pkg::CFG_W-1:0]       r_den;
    logic [wdm_pkg::CFG_W-1:0]       r_rem;
    logic [wdm_pkg::DIV_W-1:0]       r_quo;
    logic                            r_done;

    logic [wdm_pkg::CFG_W:0]         trial;
    logic [wdm_pkg::CFG_W:0]         diff;
    logic                            qbit;
    logic [wdm_pkg::DIV_W-1:0]       dividend;

    // dividend with the rounding half already added
    assign dividend = {i_num, 16'd0} + wdm_pkg::DIV_W'(i_den >> 1);

    // one restoring step
    always_comb begin
        trial = {r_rem, r_quo[wdm_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= wdm_pkg::DIV_CNT_W'(wdm_pkg::DIV_W - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= dividend;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[wdm_pkg::CFG_W-1:0] : trial[wdm_pkg::CFG_W-1:0];
            r_quo <= {r_quo[wdm_pkg::DIV_W-2:0], qbit};
        end
    end

    assign o_done   = r_done;
    assign o_weight = (|r_quo[wdm_pkg::DIV_W-1:wdm_pkg::WEIGHT_W]) ? wdm_pkg::WEIGHT_MAX
                                                                   : r_quo[wdm_pkg::WEIGHT_W-1:0];

endmodule

`default_nettype wire

>>> design/wdm_mac.sv
// ----------------------------------------------------------------------------
// wdm_mac: shared multiplier and saturating accumulator
// One 33x33 signed multiplier forms C*C, then the weight partial products;
// the term is floored to Q.29 and added with 64-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module wdm_mac (
    input  wire logic                          i_clk,
    input  wire wdm_pkg::t_mac_ctl             i_ctl,
    input  wire logic [wdm_pkg::COEF_W-1:0]    i_coef_a,
    input  wire logic [wdm_pkg::COEF_W-1:0]    i_coef_b,
    input  wire logic [wdm_pkg::WEIGHT_W-1:0]  i_weight,
    output logic      [wdm_pkg::DENS_W-1:0]    o_acc,
    output logic                               o_sat
);

    localparam int TERM_W = 50;

    logic signed [wdm_pkg::MUL_W-1:0]  mul_x;
    logic signed [wdm_pkg::MUL_W-1:0]  mul_y;
    logic signed [wdm_pkg::PROD_W-1:0] mul_p;
    logic        [wdm_pkg::PROD_W-1:0] r_mul;
    logic        [wdm_pkg::DENS_W-1:0] r_prod;
    logic        [wdm_pkg::WEIGHT_W-1:0] r_lohi;
    logic        [wdm_pkg::DENS_W-1:0] r_acc;
    logic                              r_sat;

    logic [TERM_W-1:0]                 part_sum;
    logic [wdm_pkg::DENS_W:0]          term;
    logic [wdm_pkg::DENS_W:0]          sum;

    // operand select for the shared multiplier
    always_comb begin
        case (i_ctl.op)
            wdm_pkg::MAC_PROD: begin
                mul_x = {i_coef_a[wdm_pkg::COEF_W-1], i_coef_a};
                mul_y = {i_coef_b[wdm_pkg::COEF_W-1], i_coef_b};
            end
            wdm_pkg::MAC_WLO: begin
                mul_x = {1'b0, r_mul[31:0]};
                mul_y = {16'd0, i_weight};
            end
            wdm_pkg::MAC_WHI: begin
                mul_x = {r_prod[63], r_prod[63:32]};
                mul_y = {16'd0, i_weight};
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // multiplier result and saved operands
    always_ff @(posedge i_clk) begin
        if (i_ctl.op != wdm_pkg::MAC_NOP) begin
            r_mul <= mul_p;
        end
        if (i_ctl.op == wdm_pkg::MAC_WLO) begin
            r_prod <= r_mul[wdm_pkg::DENS_W-1:0];
        end
        if (i_ctl.op == wdm_pkg::MAC_WHI) begin
            r_lohi <= r_mul[48:32];
        end
    end

    // term: full weight is p >> 29; partial is (hi + lo >> 32) >> 13
    always_comb begin
        part_sum = {r_mul[48], r_mul[48:0]} + {33'd0, r_lohi};
        if (i_ctl.full) begin
            term = {{30{r_mul[63]}}, r_mul[63:wdm_pkg::FRAC_BITS]};
        end else begin
            term = {{28{part_sum[TERM_W-1]}}, part_sum[TERM_W-1:13]};
        end
        sum = {r_acc[wdm_pkg::DENS_W-1], r_acc} + term;
    end

    // saturating accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_ctl.acc_add) begin
            if (sum[wdm_pkg::DENS_W] != sum[wdm_pkg::DENS_W-1]) begin
                r_acc <= sum[wdm_pkg::DENS_W] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                r_sat <= 1'b1;
            end else begin
                r_acc <= sum[wdm_pkg::DENS_W-1:0];
            end
        end
    end

    assign o_acc = r_acc;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

>>> design/weighted_density_matrix.sv
// ----------------------------------------------------------------------------
// weighted_density_matrix: fractional occupation density element unit
// Holds orbital coefficients and returns one weighted density element per
// read word, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_stall    i_cmd i_row i_col i_coef
//  out      source     o_out_valid / i_out_stall  o_density o_status
//  cfg      sink       i_cfg_we                   i_cfg_idx i_cfg_data
//
//  Load word, rejected or empty read: accept, then result.
//  Read word: RD, PROD, ACC per full orbital; a partial-shell orbital adds WLO
//  and WHI for the one multiplier (C*C, then two weight partial products).
//  A config write reruns the 23-step weight divider; input stalls meanwhile.
//  Reset is synchronous, active low; the coefficient RAM is not cleared.
//  The result register holds while stalled; a new word is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_density_matrix (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_cmd,
    input  wire logic [wdm_pkg::IDX_W-1:0]     i_row,
    input  wire logic [wdm_pkg::IDX_W-1:0]     i_col,
    input  wire logic [wdm_pkg::COEF_W-1:0]    i_coef,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [wdm_pkg::DENS_W-1:0]    o_density,
    output logic      [1:0]                    o_status,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [wdm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wdm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WSTRT = 4'd1;
    localparam logic [3:0] S_WDIV  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_PROD  = 4'd4;
    localparam logic [3:0] S_WLO   = 4'd5;
    localparam logic [3:0] S_WHI   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // configuration registers
    logic [wdm_pkg::CFG_W-1:0]    r_basis;
    logic [wdm_pkg::CFG_W-1:0]    r_ss;
    logic [wdm_pkg::CFG_W-1:0]    r_se;
    logic [wdm_pkg::CFG_W-1:0]    r_ec;
    logic [wdm_pkg::WEIGHT_W-1:0] r_weight;

    // sequencer state
    logic [3:0]                   r_state, n_state;
    logic [wdm_pkg::IDX_W-1:0]    r_row, n_row;
    logic [wdm_pkg::IDX_W-1:0]    r_col, n_col;
    logic [wdm_pkg::K_W-1:0]      r_k, n_k;
    logic [wdm_pkg::K_W-1:0]      r_kend, n_kend;
    logic                         r_full, n_full;
    logic                         r_early, n_early;
    logic [1:0]                   r_res_status, n_res_status;

    // output register
    logic                         r_out_valid;
    logic [wdm_pkg::DENS_W-1:0]   r_out_density;
    logic [1:0]                   r_out_status;

    logic                         in_acc;
    logic                         out_load;
    logic                         load_ok;
    logic                         read_ok;
    int                           n_eff;
    int                           kend_eff;
    logic                         ram_we;
    logic                         ram_re;
    logic [wdm_pkg::ADDR_W-1:0]   waddr;
    logic [wdm_pkg::ADDR_W-1:0]   raddr_a;
    logic [wdm_pkg::ADDR_W-1:0]   raddr_b;
    logic [wdm_pkg::COEF_W-1:0]   rdata_a;
    logic [wdm_pkg::COEF_W-1:0]   rdata_b;
    logic                         div_start;
    logic                         div_done;
    logic [wdm_pkg::WEIGHT_W-1:0] div_weight;
    wdm_pkg::t_mac_ctl            mac_ctl;
    logic [wdm_pkg::DENS_W-1:0]   acc;
    logic                         sat;

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign div_start  = (r_state == S_WSTRT);

    // range checks
    always_comb begin
        n_eff    = (32'(r_basis) < wdm_pkg::MAX_BASIS) ? 32'(r_basis) : wdm_pkg::MAX_BASIS;
        kend_eff = (32'(r_se) < wdm_pkg::MAX_ORBITALS) ? 32'(r_se) : wdm_pkg::MAX_ORBITALS;
        load_ok  = (32'(i_row) < wdm_pkg::MAX_BASIS) && (32'(i_col) < wdm_pkg::MAX_ORBITALS);
        read_ok  = (32'(i_row) < n_eff) && (32'(i_col) < n_eff);
    end

    // RAM addressing
    always_comb begin
        ram_we  = in_acc && (i_cmd == wdm_pkg::CMD_LOAD) && load_ok;
        ram_re  = (r_state == S_RD);
        waddr   = wdm_pkg::ADDR_W'(wdm_pkg::ADDR_W'(i_row) * wdm_pkg::ADDR_W'(wdm_pkg::MAX_ORBITALS)
                  + wdm_pkg::ADDR_W'(i_col));
        raddr_a = wdm_pkg::ADDR_W'(wdm_pkg::ADDR_W'(r_row) * wdm_pkg::ADDR_W'(wdm_pkg::MAX_ORBITALS)
                  + wdm_pkg::ADDR_W'(r_k[wdm_pkg::K_IDX_W-1:0]));
        raddr_b = wdm_pkg::ADDR_W'(wdm_pkg::ADDR_W'(r_col) * wdm_pkg::ADDR_W'(wdm_pkg::MAX_ORBITALS)
                  + wdm_pkg::ADDR_W'(r_k[wdm_pkg::K_IDX_W-1:0]));
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_k          = r_k;
        n_kend       = r_kend;
        n_full       = r_full;
        n_early      = r_early;
        n_res_status = r_res_status;
        mac_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_row        = i_row;
                    n_col        = i_col;
                    n_k          = '0;
                    n_kend       = wdm_pkg::K_W'(kend_eff);
                    n_early      = 1'b1;
                    n_res_status = wdm_pkg::ST_OK;
                    n_state      = S_FIN;
                    if (i_cmd == wdm_pkg::CMD_LOAD) begin
                        n_res_status = load_ok ? wdm_pkg::ST_OK : wdm_pkg::ST_RANGE;
                    end else if (!read_ok) begin
                        n_res_status = wdm_pkg::ST_RANGE;
                    end else if ((r_ec != '0) && (kend_eff != 0)) begin
                        n_early        = 1'b0;
                        mac_ctl.acc_clr = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            S_WSTRT: n_state = S_WDIV;
            S_WDIV: begin
                if (div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: n_state = S_PROD;
            S_PROD: begin
                mac_ctl.op = wdm_pkg::MAC_PROD;
                n_full     = (32'(r_k) < 32'(r_ss));
                n_state    = n_full ? S_ACC : S_WLO;
            end
            S_WLO: begin
                mac_ctl.op = wdm_pkg::MAC_WLO;
                n_state    = S_WHI;
            end
            S_WHI: begin
                mac_ctl.op = wdm_pkg::MAC_WHI;
                n_state    = S_ACC;
            end
            S_ACC: begin
                mac_ctl.acc_add = 1'b1;
                mac_ctl.full    = r_full;
                n_k             = r_k + 1'b1;
                n_state         = (n_k == r_kend) ? S_FIN : S_RD;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // any register write reruns the weight divider
        if (i_cfg_we) begin
            n_state = S_WSTRT;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_row        <= n_row;
        r_col        <= n_col;
        r_k          <= n_k;
        r_kend       <= n_kend;
        r_full       <= n_full;
        r_early      <= n_early;
        r_res_status <= n_res_status;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis <= wdm_pkg::CFG_W'(1);
            r_ss    <= '0;
            r_se    <= '0;
            r_ec    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wdm_pkg::CFG_BASIS:       r_basis <= i_cfg_data;
                wdm_pkg::CFG_SHELL_START: r_ss    <= i_cfg_data;
                wdm_pkg::CFG_SHELL_END:   r_se    <= i_cfg_data;
                wdm_pkg::CFG_ELECTRONS:   r_ec    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // partial shell weight, zero unless the shell is proper and reached
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if ((r_state == S_WDIV) && div_done) begin
            r_weight <= ((r_se > r_ss) && (r_ec > r_ss)) ? div_weight : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_density <= r_early ? '0 : acc;
            r_out_status  <= r_early ? r_res_status : (sat ? wdm_pkg::ST_SAT : wdm_pkg::ST_OK);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_density   = r_out_density;
    assign o_status    = r_out_status;

    wdm_coef_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (waddr),
        .i_wdata   (i_coef),
        .i_re      (ram_re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    wdm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (r_ec - r_ss),
        .i_den    (r_se - r_ss),
        .o_done   (div_done),
        .o_weight (div_weight)
    );

    wdm_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_coef_a (rdata_a),
        .i_coef_b (rdata_b),
        .i_weight (r_weight),
        .o_acc    (acc),
        .o_sat    (sat)
    );

endmodule

`default_nettype wire

>>> design/wdm_checker.sv
// ----------------------------------------------------------------------------
// wdm_checker: port-level checks for the density matrix unit
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module wdm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [wdm_pkg::DENS_W-1:0]    o_density,
    input wire logic [1:0]                    o_status
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_density) && $stable(o_status)))
        else $error("stalled result word changed");

    // an accepted word keeps the unit busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after accept");

    // a rejected word carries a zero density
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == wdm_pkg::ST_RANGE)) |-> (o_density == '0))
        else $error("range error with nonzero density");

    // a saturated result sits at one of the limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == wdm_pkg::ST_SAT)) |->
            ((o_density == {1'b1, 63'd0}) || (o_density == {1'b0, {63{1'b1}}})))
        else $error("saturated result off the limits");

endmodule

bind weighted_density_matrix wdm_checker u_wdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_density   (o_density),
    .o_status    (o_status)
);

`default_nettype wire
